// ===== src/cscm_pkg.sv =====
package cscm_pkg;

   localparam int SEG_DEPTH_DEFAULT = 4096;
   localparam int ID_DEPTH_DEFAULT  = 4096;
   localparam int QUEUE_DEPTH       = 2;

   localparam int KIND_W   = 3;
   localparam int ID_W     = 12;
   localparam int RANK_W   = 13;
   localparam int OFFS_W   = 40;
   localparam int COORD_W  = 32;
   localparam int POS_W    = 40;
   localparam int OPOS_W   = 41;
   localparam int STATUS_W = 2;
   localparam int GAP_W    = 16;
   localparam int COUNT_W  = 13;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   localparam logic [ID_W-1:0]       UNKNOWN_ID  = 12'hFFF;
   localparam logic [GAP_W-1:0]      GAP_RESET   = 16'd200;
   localparam logic [COUNT_W-1:0]    COUNT_RESET = 13'd0;

   localparam logic [CSR_IDX_W-1:0]  CSR_GAP_SIZE    = 8'd0;
   localparam logic [CSR_IDX_W-1:0]  CSR_INDEX_COUNT = 8'd1;

   localparam logic [STATUS_W-1:0]   STATUS_FOUND   = 2'd0;
   localparam logic [STATUS_W-1:0]   STATUS_UNKNOWN = 2'd1;
   localparam logic [STATUS_W-1:0]   STATUS_MISS    = 2'd2;

   localparam logic [KIND_W-1:0] KIND_SEG = 3'd0;
   localparam logic [KIND_W-1:0] KIND_IDX = 3'd1;
   localparam logic [KIND_W-1:0] KIND_PTR = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SCF = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FWD = 3'd4;
   localparam logic [KIND_W-1:0] KIND_REV = 3'd5;

   typedef enum logic [2:0] {
      OP_SEG,
      OP_IDX,
      OP_PTR,
      OP_SCF,
      OP_FWD,
      OP_REV
   } op_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [ID_W-1:0]    slot;
      logic [ID_W-1:0]    scaffold_id;
      logic [ID_W-1:0]    contig_id;
      logic [RANK_W-1:0]  seg_rank;
      logic [ID_W-1:0]    seg_ref;
      logic [OFFS_W-1:0]  scaffold_offset;
      logic               reversed;
      logic [COORD_W-1:0] contig_start;
      logic [COORD_W-1:0] seg_length;
      logic [POS_W-1:0]   position;
      logic               count_gaps;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     out_seq_id;
      logic [OPOS_W-1:0]   out_position;
   } rsp_type;

   typedef struct packed {
      op_type  op;
      logic    id_unknown;
      req_type req;
   } item_type;

endpackage

// ===== src/cscm_front.sv =====
module cscm_front (
   input  logic               req_valid,
   input  cscm_pkg::req_type  req_payload,
   output logic               req_stall,
   input  logic               q_full,
   output logic               q_push,
   output cscm_pkg::item_type q_item
);

   logic known;

   // Classify the beat; drop unused kinds without queueing them.
   always_comb begin
      known           = 1'b1;
      q_item.op       = cscm_pkg::OP_SEG;
      q_item.req      = req_payload;
      q_item.id_unknown = 1'b0;
      unique case (req_payload.kind)
         cscm_pkg::KIND_SEG: q_item.op = cscm_pkg::OP_SEG;
         cscm_pkg::KIND_IDX: q_item.op = cscm_pkg::OP_IDX;
         cscm_pkg::KIND_PTR: q_item.op = cscm_pkg::OP_PTR;
         cscm_pkg::KIND_SCF: q_item.op = cscm_pkg::OP_SCF;
         cscm_pkg::KIND_FWD: begin
            q_item.op         = cscm_pkg::OP_FWD;
            q_item.id_unknown = (req_payload.contig_id == cscm_pkg::UNKNOWN_ID);
         end
         cscm_pkg::KIND_REV: begin
            q_item.op         = cscm_pkg::OP_REV;
            q_item.id_unknown = (req_payload.scaffold_id == cscm_pkg::UNKNOWN_ID);
         end
         default: known = 1'b0;
      endcase
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full && known;

endmodule

// ===== src/cscm_queue.sv =====
module cscm_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cscm_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output cscm_pkg::item_type head_item
);

   localparam int PW = (cscm_pkg::QUEUE_DEPTH > 1) ? $clog2(cscm_pkg::QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(cscm_pkg::QUEUE_DEPTH + 1);

   cscm_pkg::item_type store_ff [cscm_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic          do_push, do_pop;

   assign full       = (fill_ff == CW'(cscm_pkg::QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_item  = store_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(cscm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(cscm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== src/cscm_back.sv =====
module cscm_back #(
   parameter int SEG_DEPTH = cscm_pkg::SEG_DEPTH_DEFAULT,
   parameter int ID_DEPTH  = cscm_pkg::ID_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  cscm_pkg::item_type                q_item,
   output logic                              q_pop,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cscm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cscm_pkg::CSR_DATA_W-1:0]   csr_data,
   output logic                              rsp_valid,
   output cscm_pkg::rsp_type                 rsp_payload,
   input  logic                              rsp_stall
);

   localparam int SAW  = $clog2(SEG_DEPTH);
   localparam int IAW  = $clog2(ID_DEPTH);
   localparam int XW   = 17;
   localparam int IW   = (SAW + 1 > cscm_pkg::RANK_W) ? SAW + 1 : cscm_pkg::RANK_W;
   localparam int SUMW = IW + 1;
   localparam int LW   = cscm_pkg::POS_W + 2;
   localparam int PW   = cscm_pkg::RANK_W + cscm_pkg::GAP_W;
   localparam int OW   = cscm_pkg::OPOS_W;

   typedef struct packed {
      logic [cscm_pkg::ID_W-1:0]    scaffold;
      logic [cscm_pkg::RANK_W-1:0]  order;
      logic [cscm_pkg::OFFS_W-1:0]  offset;
      logic [cscm_pkg::ID_W-1:0]    contig;
      logic                         flip;
      logic [cscm_pkg::COORD_W-1:0] start;
      logic [cscm_pkg::COORD_W-1:0] size;
   } seg_entry_type;

   typedef struct packed {
      logic [cscm_pkg::COORD_W-1:0] seg_end;
      logic [cscm_pkg::ID_W-1:0]    seg;
   } idx_entry_type;

   typedef struct packed {
      logic [cscm_pkg::ID_W-1:0]   first;
      logic [cscm_pkg::RANK_W-1:0] segs;
   } scf_entry_type;

   typedef enum logic [3:0] {
      IDLE,
      FW_PTR,
      FW_IDX,
      FW_SEG,
      FW_POS,
      FW_GAP,
      RV_HDR,
      RV_SEG,
      RV_FIN,
      RESP
   } state_type;

   seg_entry_type             seg_mem [SEG_DEPTH];
   idx_entry_type             idx_mem [SEG_DEPTH];
   logic [cscm_pkg::ID_W-1:0] cf_mem  [ID_DEPTH];
   scf_entry_type             scf_mem [ID_DEPTH];

   seg_entry_type             seg_rd_ff;
   idx_entry_type             idx_rd_ff;
   logic [cscm_pkg::ID_W-1:0] cf_rd_ff;
   scf_entry_type             scf_rd_ff;

   state_type                     state_ff;
   logic [cscm_pkg::GAP_W-1:0]    gap_ff;
   logic [cscm_pkg::COUNT_W-1:0]  count_ff;
   logic [cscm_pkg::POS_W-1:0]    pos_ff;
   logic                          gaps_ff;
   logic [IW-1:0]                 i_ff;
   logic [cscm_pkg::ID_W-1:0]     first_ff;
   logic [cscm_pkg::RANK_W-1:0]   n_ff;
   logic signed [LW-1:0]          l_ff;
   logic                          ingap_ff;
   logic [OW-1:0]                 t_ff;
   logic [PW-1:0]                 prod_ff;
   cscm_pkg::rsp_type             res_ff;
   logic                          rsp_valid_ff;
   cscm_pkg::rsp_type             rsp_ff;

   logic                 seg_we, idx_we, cf_we, scf_we;
   logic [SAW-1:0]       wr_seg_addr;
   logic [IAW-1:0]       wr_id_addr;
   logic [XW-1:0]        slot_x, cid_x, sid_x, ref_x;
   logic                 seg_re, idx_re, cf_re, scf_re;
   logic [SAW-1:0]       seg_ra, idx_ra;
   logic [IAW-1:0]       cf_ra, scf_ra;
   logic [IW-1:0]        lim, ptr_i, i_next, n_i;
   logic [SUMW-1:0]      rv_addr;
   logic                 idx_hit;
   logic signed [LW-1:0] l_sub, l_new;
   logic                 more_gap, rv_more;
   cscm_pkg::req_type    hq;

   assign hq       = q_item.req;
   assign q_pop    = (state_ff == IDLE) && q_valid;
   assign csr_ready = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Table slots and ids are taken modulo the table depth.
   assign slot_x      = XW'(hq.slot);
   assign cid_x       = XW'(hq.contig_id);
   assign sid_x       = XW'(hq.scaffold_id);
   assign ref_x       = XW'(idx_rd_ff.seg);
   assign wr_seg_addr = slot_x[SAW-1:0];
   assign wr_id_addr  = slot_x[IAW-1:0];

   assign seg_we = q_pop && (q_item.op == cscm_pkg::OP_SEG);
   assign idx_we = q_pop && (q_item.op == cscm_pkg::OP_IDX);
   assign cf_we  = q_pop && (q_item.op == cscm_pkg::OP_PTR);
   assign scf_we = q_pop && (q_item.op == cscm_pkg::OP_SCF);

   // Walk limit: index_count capped at the table depth.
   assign lim     = (IW'(count_ff) < IW'(SEG_DEPTH)) ? IW'(count_ff) : IW'(SEG_DEPTH);
   assign ptr_i   = IW'(cf_rd_ff);
   assign i_next  = i_ff + 1'b1;
   assign idx_hit = ({{(cscm_pkg::POS_W - cscm_pkg::COORD_W){1'b0}}, idx_rd_ff.seg_end}
                     >= pos_ff);
   assign n_i     = IW'(n_ff);

   // One reverse step: take off a segment, then, when gaps count and more is left, the gap that follows it.
   assign l_sub    = l_ff - LW'(seg_rd_ff.size);
   assign more_gap = gaps_ff && (i_next < n_i) && (l_sub > 0);
   assign l_new    = more_gap ? l_sub - LW'(gap_ff) : l_sub;
   assign rv_more  = (i_next < n_i) && (l_new > 0);
   assign rv_addr  = SUMW'(first_ff) + SUMW'(i_next);

   always_comb begin
      seg_re = 1'b0;
      idx_re = 1'b0;
      cf_re  = 1'b0;
      scf_re = 1'b0;
      seg_ra = '0;
      idx_ra = '0;
      cf_ra  = cid_x[IAW-1:0];
      scf_ra = sid_x[IAW-1:0];
      unique case (state_ff)
         IDLE: begin
            cf_re  = q_pop && (q_item.op == cscm_pkg::OP_FWD) && !q_item.id_unknown;
            scf_re = q_pop && (q_item.op == cscm_pkg::OP_REV) && !q_item.id_unknown;
         end
         FW_PTR: begin
            idx_re = ptr_i < lim;
            idx_ra = ptr_i[SAW-1:0];
         end
         FW_IDX: begin
            if (idx_hit) begin
               seg_re = 1'b1;
               seg_ra = ref_x[SAW-1:0];
            end else begin
               idx_re = i_next < lim;
               idx_ra = i_next[SAW-1:0];
            end
         end
         RV_HDR: begin
            seg_re = 1'b1;
            seg_ra = SAW'(scf_rd_ff.first);
            if (SAW > cscm_pkg::ID_W) begin
               seg_ra = SAW'(scf_rd_ff.first);
            end
         end
         RV_SEG: begin
            seg_re = rv_more;
            seg_ra = rv_addr[SAW-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (seg_we) begin
         seg_mem[wr_seg_addr] <= '{scaffold: hq.scaffold_id, order: hq.seg_rank,
                                   offset: hq.scaffold_offset, contig: hq.contig_id,
                                   flip: hq.reversed, start: hq.contig_start,
                                   size: hq.seg_length};
      end
      if (seg_re) begin
         seg_rd_ff <= seg_mem[seg_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (idx_we) begin
         idx_mem[wr_seg_addr] <= '{seg_end: hq.position[cscm_pkg::COORD_W-1:0],
                                   seg: hq.seg_ref};
      end
      if (idx_re) begin
         idx_rd_ff <= idx_mem[idx_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (cf_we) begin
         cf_mem[wr_id_addr] <= hq.seg_ref;
      end
      if (cf_re) begin
         cf_rd_ff <= cf_mem[cf_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (scf_we) begin
         scf_mem[wr_id_addr] <= '{first: hq.seg_ref, segs: hq.seg_rank};
      end
      if (scf_re) begin
         scf_rd_ff <= scf_mem[scf_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         gap_ff       <= cscm_pkg::GAP_RESET;
         count_ff     <= cscm_pkg::COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            if (csr_index == cscm_pkg::CSR_GAP_SIZE) begin
               gap_ff <= csr_data;
            end else if (csr_index == cscm_pkg::CSR_INDEX_COUNT) begin
               count_ff <= csr_data[cscm_pkg::COUNT_W-1:0];
            end
         end
         if (!rsp_stall && state_ff != RESP) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               pos_ff  <= hq.position;
               gaps_ff <= hq.count_gaps;
               res_ff  <= '{status: cscm_pkg::STATUS_UNKNOWN,
                            out_seq_id: cscm_pkg::UNKNOWN_ID, out_position: '0};
               if (q_pop && q_item.op == cscm_pkg::OP_FWD) begin
                  state_ff <= q_item.id_unknown ? RESP : FW_PTR;
               end else if (q_pop && q_item.op == cscm_pkg::OP_REV) begin
                  state_ff <= q_item.id_unknown ? RESP : RV_HDR;
               end
            end
            FW_PTR: begin
               i_ff <= ptr_i;
               if (!(ptr_i < lim)) begin
                  res_ff.status <= cscm_pkg::STATUS_MISS;
                  state_ff      <= RESP;
               end else begin
                  state_ff <= FW_IDX;
               end
            end
            FW_IDX: begin
               if (idx_hit) begin
                  state_ff <= FW_SEG;
               end else begin
                  i_ff <= i_next;
                  if (!(i_next < lim)) begin
                     res_ff.status <= cscm_pkg::STATUS_MISS;
                     state_ff      <= RESP;
                  end
               end
            end
            FW_SEG: begin
               if (seg_rd_ff.flip) begin
                  t_ff <= OW'(seg_rd_ff.offset) + OW'(seg_rd_ff.start)
                          + OW'(seg_rd_ff.size) + OW'(1);
               end else begin
                  t_ff <= OW'(seg_rd_ff.offset) - OW'(seg_rd_ff.start);
               end
               prod_ff  <= PW'(seg_rd_ff.order) * PW'(gap_ff);
               state_ff <= FW_POS;
            end
            FW_POS: begin
               t_ff     <= seg_rd_ff.flip ? t_ff - OW'(pos_ff) : t_ff + OW'(pos_ff);
               state_ff <= FW_GAP;
            end
            FW_GAP: begin
               res_ff.status       <= cscm_pkg::STATUS_FOUND;
               res_ff.out_seq_id   <= seg_rd_ff.scaffold;
               res_ff.out_position <= t_ff + (gaps_ff ? OW'(prod_ff) : '0);
               state_ff            <= RESP;
            end
            RV_HDR: begin
               first_ff <= scf_rd_ff.first;
               n_ff     <= scf_rd_ff.segs;
               i_ff     <= '0;
               l_ff     <= LW'(pos_ff);
               if (pos_ff == '0 || scf_rd_ff.segs == '0) begin
                  res_ff.status <= cscm_pkg::STATUS_MISS;
                  state_ff      <= RESP;
               end else begin
                  state_ff <= RV_SEG;
               end
            end
            RV_SEG: begin
               l_ff     <= l_new;
               i_ff     <= i_next;
               ingap_ff <= more_gap;
               if (!rv_more) begin
                  state_ff <= RV_FIN;
               end
            end
            RV_FIN: begin
               if (l_ff > 0 || ingap_ff) begin
                  res_ff.status <= cscm_pkg::STATUS_MISS;
               end else begin
                  res_ff.status     <= cscm_pkg::STATUS_FOUND;
                  res_ff.out_seq_id <= seg_rd_ff.contig;
                  if (seg_rd_ff.flip) begin
                     res_ff.out_position <= OW'(LW'(seg_rd_ff.start) - l_ff + LW'(1));
                  end else begin
                     res_ff.out_position <= OW'(LW'(seg_rd_ff.start) + LW'(seg_rd_ff.size)
                                                + l_ff);
                  end
               end
               state_ff <= RESP;
            end
            RESP: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_ff       <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule

// ===== src/contig_scaffold_coordinate_map.sv =====
// Channel   Direction  Handshake           Payload
// req_      in         req_valid/req_stall cscm_pkg::req_type, one query or table write
// rsp_      out        rsp_valid/rsp_stall cscm_pkg::rsp_type, one result per query
// csr_      in         csr_valid/csr_ready register index and write data
//
// A beat leaves the queue in the cycle after acceptance at the earliest; table writes are
// done as it leaves. A forward query reads the contig pointer, walks the index past the
// entries that end before the position, reads the segment, then adds position and gap sum;
// a reverse query reads the scaffold header, then subtracts segments and gaps. Each walk is
// paced by the single registered read port of each table, one entry per step.
// Reset is synchronous; tables hold no reset. Either side may stall on its own: the
// two-beat queue and the result register part the two sides.
module contig_scaffold_coordinate_map #(
   parameter int SEG_DEPTH = cscm_pkg::SEG_DEPTH_DEFAULT,
   parameter int ID_DEPTH  = cscm_pkg::ID_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  cscm_pkg::req_type               req_payload,
   output logic                            req_stall,
   output logic                            rsp_valid,
   output cscm_pkg::rsp_type               rsp_payload,
   input  logic                            rsp_stall,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cscm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cscm_pkg::CSR_DATA_W-1:0] csr_data
);

   logic               q_full, q_push, q_pop, q_valid;
   cscm_pkg::item_type push_item, head_item;

   // Classify each beat and drop unused kinds.
   cscm_front u_front (
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_item      (push_item)
   );

   // Hold classified beats until the back end is free.
   cscm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (push_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_item  (head_item)
   );

   // Tables, walk sequencer, registers and result register.
   cscm_back #(
      .SEG_DEPTH (SEG_DEPTH),
      .ID_DEPTH  (ID_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_item      (head_item),
      .q_pop       (q_pop),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .rsp_stall   (rsp_stall)
   );

endmodule

// ===== sim/cscm_checker.sv =====
module cscm_checker
   import cscm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_payload,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    errors,
   output int                    pending,
   output logic                  beat_seen
);

   localparam int DEPTH = 4096;

   bit [ID_W-1:0]    seg_scf   [DEPTH];
   bit [RANK_W-1:0]  seg_rank  [DEPTH];
   bit [OFFS_W-1:0]  seg_offs  [DEPTH];
   bit [ID_W-1:0]    seg_ctg   [DEPTH];
   bit               seg_flip  [DEPTH];
   bit [COORD_W-1:0] seg_begin [DEPTH];
   bit [COORD_W-1:0] seg_len   [DEPTH];
   bit [COORD_W-1:0] idx_end   [DEPTH];
   bit [ID_W-1:0]    idx_seg   [DEPTH];
   bit [ID_W-1:0]    ctg_first [DEPTH];
   bit [ID_W-1:0]    scf_first [DEPTH];
   bit [RANK_W-1:0]  scf_count [DEPTH];
   bit [GAP_W-1:0]   gap_len;
   bit [COUNT_W-1:0] idx_count;

   rsp_type coords_due[$];

   assign pending = coords_due.size();

   function automatic rsp_type miss(logic [STATUS_W-1:0] code);
      rsp_type m;
      m.status       = code;
      m.out_seq_id   = UNKNOWN_ID;
      m.out_position = '0;
      return m;
   endfunction

   function automatic rsp_type contig_to_scaffold(req_type r);
      rsp_type     m;
      int unsigned lim, i;
      bit [11:0]   s;
      bit [63:0]   p;
      if (r.contig_id == UNKNOWN_ID) return miss(STATUS_UNKNOWN);
      lim = (idx_count < DEPTH) ? idx_count : DEPTH;
      i   = ctg_first[r.contig_id];
      while (i < lim && 64'(idx_end[i]) < 64'(r.position)) i++;
      if (i >= lim) return miss(STATUS_MISS);
      s = idx_seg[i];
      if (seg_flip[s])
         p = 64'(seg_offs[s]) + 64'(seg_begin[s]) + 64'(seg_len[s]) - 64'(r.position) + 1;
      else
         p = 64'(seg_offs[s]) + 64'(r.position) - 64'(seg_begin[s]);
      if (r.count_gaps) p += 64'(seg_rank[s]) * 64'(gap_len);
      m.status       = STATUS_FOUND;
      m.out_seq_id   = seg_scf[s];
      m.out_position = p[OPOS_W-1:0];
      return m;
   endfunction

   function automatic rsp_type scaffold_to_contig(req_type r);
      rsp_type     m;
      int unsigned first, n, i;
      bit [11:0]   s;
      longint      left;
      bit          in_gap;
      bit [63:0]   p;
      if (r.scaffold_id == UNKNOWN_ID) return miss(STATUS_UNKNOWN);
      first  = scf_first[r.scaffold_id];
      n      = scf_count[r.scaffold_id];
      left   = longint'(r.position);
      in_gap = 0;
      i      = 0;
      if (left <= 0 || n == 0) return miss(STATUS_MISS);
      // peel off whole segments, and the gap after each but the last
      while (i < n && left > 0) begin
         left  -= longint'(seg_len[(first + i) % DEPTH]);
         in_gap = 0;
         i++;
         if (r.count_gaps && i < n && left > 0) begin
            left  -= longint'(gap_len);
            in_gap = 1;
         end
      end
      if (left > 0 || in_gap) return miss(STATUS_MISS);
      s = (first + i - 1) % DEPTH;
      if (seg_flip[s]) p = 64'(longint'(seg_begin[s]) - left + 1);
      else             p = 64'(longint'(seg_begin[s]) + longint'(seg_len[s]) + left);
      m.status       = STATUS_FOUND;
      m.out_seq_id   = seg_ctg[s];
      m.out_position = p[OPOS_W-1:0];
      return m;
   endfunction

   task automatic report(string field, logic [63:0] want, logic [63:0] got);
      errors++;
      $display("%0t mismatch %s: expected %h actual %h", $time, field, want, got);
   endtask

   initial errors = 0;

   always @(posedge clock) begin
      rsp_type want;
      logic    seen;
      seen = 1'b0;
      if (reset) begin
         gap_len   <= GAP_RESET;
         idx_count <= COUNT_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            seen = 1'b1;
            if (csr_index == CSR_GAP_SIZE)    gap_len   <= csr_data;
            if (csr_index == CSR_INDEX_COUNT) idx_count <= csr_data[COUNT_W-1:0];
         end
         if (req_valid && !req_stall) begin
            seen = 1'b1;
            case (req_payload.kind)
               KIND_SEG: begin
                  seg_scf[req_payload.slot]   = req_payload.scaffold_id;
                  seg_rank[req_payload.slot]  = req_payload.seg_rank;
                  seg_offs[req_payload.slot]  = req_payload.scaffold_offset;
                  seg_ctg[req_payload.slot]   = req_payload.contig_id;
                  seg_flip[req_payload.slot]  = req_payload.reversed;
                  seg_begin[req_payload.slot] = req_payload.contig_start;
                  seg_len[req_payload.slot]   = req_payload.seg_length;
               end
               KIND_IDX: begin
                  idx_end[req_payload.slot] = req_payload.position[COORD_W-1:0];
                  idx_seg[req_payload.slot] = req_payload.seg_ref;
               end
               KIND_PTR: ctg_first[req_payload.slot] = req_payload.seg_ref;
               KIND_SCF: begin
                  scf_first[req_payload.slot] = req_payload.seg_ref;
                  scf_count[req_payload.slot] = req_payload.seg_rank;
               end
               KIND_FWD: coords_due.push_back(contig_to_scaffold(req_payload));
               KIND_REV: coords_due.push_back(scaffold_to_contig(req_payload));
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            seen = 1'b1;
            if (coords_due.size() == 0) begin
               errors++;
               $display("%0t unexpected result beat %h", $time, rsp_payload);
            end else begin
               want = coords_due.pop_front();
               if (want.status !== rsp_payload.status)
                  report("status", want.status, rsp_payload.status);
               if (want.out_seq_id !== rsp_payload.out_seq_id)
                  report("out_seq_id", want.out_seq_id, rsp_payload.out_seq_id);
               if (want.out_position !== rsp_payload.out_position)
                  report("out_position", want.out_position, rsp_payload.out_position);
            end
         end
      end
      beat_seen <= seen;
   end

endmodule

// ===== sim/tb_contig_scaffold_coordinate_map.sv =====
module tb_contig_scaffold_coordinate_map;
   import cscm_pkg::*;

   // kinds the block must swallow without a result
   localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;
   localparam int DEPTH      = 4096;
   localparam int IDLE_LIMIT = 60000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   req_type               req_payload;
   logic                  req_stall;
   logic                  rsp_valid;
   rsp_type               rsp_payload;
   logic                  rsp_stall;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int   errors;
   int   pending;
   logic beat_seen;
   int   idle_cycles;

   bit quiet;    // no idling on either side while set
   bit hold_on;  // ask the receiver for a long hold-off

   // track what has been written so no query reads an unwritten entry
   bit seg_ok [DEPTH];
   bit idx_ok [DEPTH];
   bit ptr_ok [DEPTH];
   bit scf_ok [DEPTH];
   int seg_list[$];
   int ptr_ids[$];
   int scf_ids[$];
   int unsigned live_count;

   contig_scaffold_coordinate_map dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_payload(req_payload), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_payload(rsp_payload), .rsp_stall(rsp_stall),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   cscm_checker coord_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .errors(errors), .pending(pending), .beat_seen(beat_seen)
   );

   always begin
      clock = 1'b0; #2;
      clock = 1'b1; #2;
   end

   // give up after a long stretch with no beat on any channel
   always @(posedge clock) begin
      if (reset || beat_seen) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL contig_scaffold_coordinate_map");
         $finish;
      end
   end

   // receiver: random stalls, or one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_on) begin
            rsp_stall = 1'b1;
            repeat (150) @(negedge clock);
            hold_on = 0;
         end else begin
            rsp_stall = !quiet && ($urandom_range(0, 99) < 32);
         end
      end
   end

   function automatic req_type noise();
      logic [255:0] w;
      for (int k = 0; k < 8; k++) w[k*32 +: 32] = $urandom;
      return req_type'(w[$bits(req_type)-1:0]);
   endfunction

   function automatic req_type blank(logic [KIND_W-1:0] kind);
      req_type r;
      r      = '0;
      r.kind = kind;
      return r;
   endfunction

   // all calls start and end on a falling edge
   task automatic send(req_type r);
      while (!quiet && $urandom_range(0, 99) < 32) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_payload = r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      case (r.kind)
         KIND_SEG: if (!seg_ok[r.slot]) begin
            seg_ok[r.slot] = 1;
            seg_list.push_back(r.slot);
         end
         KIND_IDX: idx_ok[r.slot] = 1;
         KIND_PTR: if (!ptr_ok[r.slot]) begin
            ptr_ok[r.slot] = 1;
            ptr_ids.push_back(r.slot);
         end
         KIND_SCF: if (!scf_ok[r.slot]) begin
            scf_ok[r.slot] = 1;
            scf_ids.push_back(r.slot);
         end
         default: ;
      endcase
   endtask

   // hold the sender until every result is in, then let writes settle
   task automatic drain();
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic segment(int slot, int ctg, int scf, int rank, longint offs,
                          bit flip, int unsigned start, int unsigned len);
      req_type r;
      r                 = blank(KIND_SEG);
      r.slot            = slot;
      r.contig_id       = ctg;
      r.scaffold_id     = scf;
      r.seg_rank        = rank;
      r.scaffold_offset = offs;
      r.reversed        = flip;
      r.contig_start    = start;
      r.seg_length      = len;
      send(r);
   endtask

   task automatic index_entry(int slot, int unsigned seg_end, int seg);
      req_type r;
      r          = blank(KIND_IDX);
      r.slot     = slot;
      r.position = seg_end;
      r.seg_ref  = seg;
      send(r);
   endtask

   task automatic table_ref(logic [KIND_W-1:0] kind, int id, int ref_val, int n);
      req_type r;
      r          = blank(kind);
      r.slot     = id;
      r.seg_ref  = ref_val;
      r.seg_rank = n;
      send(r);
   endtask

   task automatic query(logic [KIND_W-1:0] kind, int id, longint pos, bit gaps);
      req_type r;
      r             = noise();
      r.kind        = kind;
      r.contig_id   = id;
      r.scaffold_id = id;
      r.position    = pos;
      r.count_gaps  = gaps;
      send(r);
   endtask

   // pick a scaffold run that lies wholly over written segments
   task automatic pick_run(output int first, output int n);
      bit ok;
      n     = $urandom_range(0, 6);
      first = seg_list[$urandom_range(0, seg_list.size() - 1)];
      ok    = 1;
      for (int k = 0; k < n; k++) ok &= seg_ok[(first + k) % DEPTH];
      if (!ok) first = $urandom_range(0, 50);
   endtask

   task automatic make_item(output req_type r);
      int pick, first, n;
      r    = noise();
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         r.kind = KIND_SEG;
         if ($urandom_range(0, 2) != 0) r.slot = $urandom_range(0, 63);
         if ($urandom_range(0, 3) != 0) begin
            r.seg_length      = $urandom_range(1, 1500);
            r.contig_start    = $urandom_range(0, 5000);
            r.scaffold_offset = $urandom_range(0, 100000);
            r.seg_rank        = $urandom_range(0, 5);
         end
      end else if (pick < 30) begin
         r.kind    = KIND_IDX;
         r.seg_ref = seg_list[$urandom_range(0, seg_list.size() - 1)];
         if ($urandom_range(0, 2) != 0)
            r.slot = $urandom_range(0, (live_count > 0 && live_count <= DEPTH) ?
                                       live_count - 1 : 63);
         if ($urandom_range(0, 3) != 0) r.position = $urandom_range(0, 3000);
      end else if (pick < 38) begin
         r.kind = KIND_PTR;
         if ($urandom_range(0, 3) != 0) r.slot = $urandom_range(0, 31);
         if ($urandom_range(0, 3) != 0) r.seg_ref = $urandom_range(0, 70);
      end else if (pick < 45) begin
         r.kind = KIND_SCF;
         if ($urandom_range(0, 3) != 0) r.slot = $urandom_range(0, 31);
         pick_run(first, n);
         r.seg_ref  = first;
         r.seg_rank = n;
      end else if (pick < 72) begin
         r.kind      = KIND_FWD;
         r.contig_id = ($urandom_range(0, 19) == 0) ? UNKNOWN_ID :
                       ptr_ids[$urandom_range(0, ptr_ids.size() - 1)];
         if ($urandom_range(0, 4) != 0) r.position = $urandom_range(1, 3000);
      end else if (pick < 97) begin
         r.kind        = KIND_REV;
         r.scaffold_id = ($urandom_range(0, 19) == 0) ? UNKNOWN_ID :
                         scf_ids[$urandom_range(0, scf_ids.size() - 1)];
         if ($urandom_range(0, 4) != 0) r.position = $urandom_range(0, 4000);
      end else begin
         r.kind = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
      end
   endtask

   // go idle, cover the index up to the new count, then reprogram
   task automatic new_setting(logic [GAP_W-1:0] gap, int unsigned count);
      drain();
      for (int s = 0; s < count; s++)
         if (!idx_ok[s])
            index_entry(s, $urandom_range(0, 3000),
                        seg_list[$urandom_range(0, seg_list.size() - 1)]);
      drain();
      csr_write(CSR_GAP_SIZE, gap);
      csr_write(CSR_INDEX_COUNT, count);
      live_count = count;
   endtask

   task automatic random_burst(int items);
      req_type r;
      for (int k = 0; k < items; k++) begin
         make_item(r);
         send(r);
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      quiet       = 0;
      hold_on     = 0;
      live_count  = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // small hand-built map: scaffold 7 is seg 0, seg 1 (reversed), seg 2
      segment(0, 5, 7, 0, 0, 0, 0, 100);
      segment(1, 5, 7, 1, 100, 1, 100, 50);
      segment(2, 6, 7, 2, 150, 0, 0, 30);
      index_entry(0, 100, 0);
      index_entry(1, 150, 1);
      index_entry(2, 30, 2);
      table_ref(KIND_PTR, 5, 0, 0);
      table_ref(KIND_PTR, 6, 2, 0);
      table_ref(KIND_SCF, 7, 0, 3);
      table_ref(KIND_SCF, 8, 0, 0);
      // empty index: every forward walk falls off the end
      query(KIND_FWD, 5, 10, 0);
      query(KIND_FWD, UNKNOWN_ID, 10, 0);
      query(KIND_REV, UNKNOWN_ID, 10, 0);
      query(KIND_REV, 7, 0, 0);
      query(KIND_REV, 8, 5, 0);
      query(KIND_REV, 7, 101, 1);
      query(KIND_REV, 7, 1000, 0);
      query(KIND_REV, 7, 120, 0);
      query(KIND_REV, 7, 420, 1);
      table_ref(KIND_SPARE_A, 0, 0, 0);
      table_ref(KIND_SPARE_B, 0, 0, 0);

      // fill both wrap ends of the segment table so runs may cross slot zero
      for (int s = 3; s < 64; s++)
         segment(s, $urandom_range(0, 40), $urandom_range(0, 40), $urandom_range(0, 5),
                 $urandom_range(0, 100000), $urandom_range(0, 1),
                 $urandom_range(0, 5000), $urandom_range(1, 1500));
      for (int s = 4064; s < DEPTH; s++)
         segment(s, 4094, 4094, 8191, 40'hFF_FFFF_FFFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      table_ref(KIND_SCF, 4094, 4090, 8);

      new_setting(200, 64);
      query(KIND_FWD, 5, 120, 1);
      query(KIND_FWD, 5, 1, 0);
      query(KIND_FWD, 6, 20, 1);
      query(KIND_REV, 4094, 40'hFF_FFFF_FFFF, 1);
      random_burst(250);

      // fill up the block behind a stalled receiver
      new_setting(0, 0);
      hold_on = 1;
      random_burst(250);

      quiet = 1;
      new_setting(16'hFFFF, 64);
      random_burst(300);
      quiet = 0;

      new_setting($urandom, 160);
      random_burst(40);

      new_setting($urandom, $urandom_range(1, 64));
      random_burst(250);

      drain();
      if (errors == 0) $display("PASS contig_scaffold_coordinate_map");
      else $display("FAIL contig_scaffold_coordinate_map");
      $finish;
   end

endmodule
